[src/mdfs_pkg.sv]
package mdfs_pkg;

    localparam int DATA_W             = 16;
    localparam int COEF_W             = 16;
    localparam int TAP_CNT_W          = 6;
    localparam int SLOT_W             = 5;
    localparam int CFG_IDX_W          = 1;
    localparam int CFG_DATA_W         = 6;
    localparam int DEF_MAX_TAPS       = 32;
    localparam int DEF_COEF_FRAC_BITS = 10;
    localparam int DEF_TAPS           = 21;

    localparam logic [CFG_IDX_W-1:0] REG_FILTER_ENABLE = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_TAP_COUNT     = 1'b1;

    localparam logic KIND_SAMPLE = 1'b0;
    localparam logic KIND_COEF   = 1'b1;

    localparam logic AXIS_X = 1'b0;
    localparam logic AXIS_Y = 1'b1;

    typedef struct packed {
        logic clear;
        logic shift;
        logic rotate;
    } t_cell_ctl;

endpackage

[src/mouse_delta_fir_smoother.sv]
// Two-axis FIR smoother for relative mouse deltas with Q-format coefficients. Each axis keeps
// its history and coefficients in a ring of MAX_TAPS cells, cell k holding the sample that is
// k transactions old and the coefficient for that age. A movement sample with filtering on
// shifts into the ring, then the ring turns once while one shared multiply-accumulate per axis
// takes the pair at cell 0 each cycle. With filtering off a sample goes straight to the result
// register. The next sample is accepted only once the result is in the output register; a
// coefficient write leaves the block idle. A filtered result is floor-shifted by COEF_FRAC_BITS
// and saturated to 16 bits. A coefficient or valid tap count write clears both histories.
// The user must write configuration only while the block is idle; no logic here enforces it.
module mouse_delta_fir_smoother #(
    parameter int MAX_TAPS       = mdfs_pkg::DEF_MAX_TAPS,
    parameter int COEF_FRAC_BITS = mdfs_pkg::DEF_COEF_FRAC_BITS
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_in_valid,
    output logic                              o_in_ready,
    input  logic                              i_kind,
    input  logic signed [mdfs_pkg::DATA_W-1:0] i_delta_x,
    input  logic signed [mdfs_pkg::DATA_W-1:0] i_delta_y,
    input  logic                              i_coef_axis,
    input  logic [mdfs_pkg::SLOT_W-1:0]       i_coef_slot,
    input  logic signed [mdfs_pkg::COEF_W-1:0] i_coef_value,
    output logic                              o_out_valid,
    input  logic                              i_out_ready,
    output logic signed [mdfs_pkg::DATA_W-1:0] o_out_x,
    output logic signed [mdfs_pkg::DATA_W-1:0] o_out_y,
    input  logic                              i_cfg_we,
    input  logic [mdfs_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [mdfs_pkg::CFG_DATA_W-1:0]   i_cfg_data
);
    import mdfs_pkg::*;

    localparam int StepW   = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
    localparam int ProdW   = DATA_W + COEF_W;
    localparam int AccW    = ProdW + StepW + 1;
    localparam int DefTaps = (DEF_TAPS < MAX_TAPS) ? DEF_TAPS : MAX_TAPS;
    localparam int Unity   = 1 << COEF_FRAC_BITS;
    localparam int DefCoef = Unity / DefTaps;
    localparam int DefRem  = Unity % DefTaps;
    localparam int DefMid  = DefTaps / 2;

    typedef enum logic [2:0] {
        S_IDLE,
        S_RUN,
        S_ACC,
        S_SAT,
        S_DONE
    } t_state;

    t_state                   r_state;
    logic [StepW-1:0]         r_step;
    logic                     r_enable;
    logic [TAP_CNT_W-1:0]     r_taps;
    logic                     r_out_valid;
    logic [DATA_W-1:0]        r_out_x;
    logic [DATA_W-1:0]        r_out_y;
    logic [DATA_W-1:0]        r_res_x;
    logic [DATA_W-1:0]        r_res_y;
    logic                     r_pv;
    logic signed [ProdW-1:0]  r_prod_x;
    logic signed [ProdW-1:0]  r_prod_y;
    logic signed [AccW-1:0]   r_acc_x;
    logic signed [AccW-1:0]   r_acc_y;

    logic                     in_accept;
    logic                     take_sample;
    logic                     take_coef;
    logic                     tap_write;
    logic                     out_load;
    t_cell_ctl                cell_ctl;
    logic [DATA_W-1:0]        sat_x;
    logic [DATA_W-1:0]        sat_y;

    logic [DATA_W-1:0] w_hist_x [MAX_TAPS];
    logic [DATA_W-1:0] w_hist_y [MAX_TAPS];
    logic [COEF_W-1:0] w_coef_x [MAX_TAPS];
    logic [COEF_W-1:0] w_coef_y [MAX_TAPS];

    assign o_in_ready  = (r_state == S_IDLE);
    assign in_accept   = i_in_valid && o_in_ready;
    assign take_sample = in_accept && (i_kind == KIND_SAMPLE);
    assign take_coef   = in_accept && (i_kind == KIND_COEF);
    assign tap_write   = i_cfg_we && (i_cfg_idx == REG_TAP_COUNT) && (i_cfg_data != '0)
                         && (int'(i_cfg_data) <= MAX_TAPS);
    assign out_load    = (r_state == S_DONE) && (!r_out_valid || i_out_ready);

    assign cell_ctl.clear  = take_coef || tap_write;
    assign cell_ctl.shift  = take_sample && r_enable;
    assign cell_ctl.rotate = (r_state == S_RUN);

    // config registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_enable <= 1'b0;
            r_taps   <= TAP_CNT_W'(DefTaps);
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_FILTER_ENABLE: r_enable <= i_cfg_data[0];
                REG_TAP_COUNT: begin
                    if (tap_write) begin
                        r_taps <= i_cfg_data[TAP_CNT_W-1:0];
                    end
                end
                default: ;
            endcase
        end
    end

    // ring of cells
    for (genvar g = 0; g < MAX_TAPS; g++) begin : g_cell
        localparam int CellCoef = ((g < DefTaps) ? DefCoef : 0) + ((g == DefMid) ? DefRem : 0);
        localparam int Next     = (g + 1) % MAX_TAPS;
        localparam int Prev     = (g == 0) ? 0 : g - 1;

        logic we_x;
        logic we_y;
        logic [DATA_W-1:0] sh_x;
        logic [DATA_W-1:0] sh_y;

        assign we_x = take_coef && (int'(i_coef_slot) == g) && (i_coef_axis == AXIS_X);
        assign we_y = take_coef && (int'(i_coef_slot) == g) && (i_coef_axis == AXIS_Y);
        assign sh_x = (g == 0) ? i_delta_x : w_hist_x[Prev];
        assign sh_y = (g == 0) ? i_delta_y : w_hist_y[Prev];

        mdfs_cell #(
            .RST_COEF (COEF_W'(CellCoef))
        ) u_cell (
            .i_clk        (i_clk),
            .i_rst_n      (i_rst_n),
            .i_ctl        (cell_ctl),
            .i_coef_we_x  (we_x),
            .i_coef_we_y  (we_y),
            .i_coef_value (i_coef_value),
            .i_shift_x    (sh_x),
            .i_shift_y    (sh_y),
            .i_rot_hist_x (w_hist_x[Next]),
            .i_rot_hist_y (w_hist_y[Next]),
            .i_rot_coef_x (w_coef_x[Next]),
            .i_rot_coef_y (w_coef_y[Next]),
            .o_hist_x     (w_hist_x[g]),
            .o_hist_y     (w_hist_y[g]),
            .o_coef_x     (w_coef_x[g]),
            .o_coef_y     (w_coef_y[g])
        );
    end

    // shared multiply-accumulate
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pv <= 1'b0;
        end else begin
            r_pv <= (r_state == S_RUN) && (int'(r_step) < int'(r_taps));
        end
    end

    always_ff @(posedge i_clk) begin
        r_prod_x <= $signed(w_hist_x[0]) * $signed(w_coef_x[0]);
        r_prod_y <= $signed(w_hist_y[0]) * $signed(w_coef_y[0]);
        if (in_accept) begin
            r_acc_x <= '0;
            r_acc_y <= '0;
        end else if (r_pv) begin
            r_acc_x <= r_acc_x + AccW'(r_prod_x);
            r_acc_y <= r_acc_y + AccW'(r_prod_y);
        end
    end

    function automatic logic [DATA_W-1:0] sat16(input logic signed [AccW-1:0] acc);
        logic signed [AccW-1:0] q;
        logic [AccW-DATA_W:0]   hi;
        q  = acc >>> COEF_FRAC_BITS;
        hi = q[AccW-1:DATA_W-1];
        if ((&hi) || !(|hi)) begin
            return q[DATA_W-1:0];
        end
        return q[AccW-1] ? {1'b1, {(DATA_W-1){1'b0}}} : {1'b0, {(DATA_W-1){1'b1}}};
    endfunction

    assign sat_x = sat16(r_acc_x);
    assign sat_y = sat16(r_acc_y);

    // control and result registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_step      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (take_sample) begin
                        r_step <= '0;
                        if (r_enable) begin
                            r_state <= S_RUN;
                        end else begin
                            r_res_x <= i_delta_x;
                            r_res_y <= i_delta_y;
                            r_state <= S_DONE;
                        end
                    end
                end
                S_RUN: begin
                    r_step <= r_step + 1'b1;
                    if (r_step == StepW'(MAX_TAPS - 1)) begin
                        r_state <= S_ACC;
                    end
                end
                S_ACC: begin
                    r_state <= S_SAT;
                end
                S_SAT: begin
                    r_res_x <= sat_x;
                    r_res_y <= sat_y;
                    r_state <= S_DONE;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase

            if (out_load) begin
                r_out_valid <= 1'b1;
                r_out_x     <= r_res_x;
                r_out_y     <= r_res_y;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_x     = r_out_x;
    assign o_out_y     = r_out_y;

    a_out_from_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> $past(r_state == S_DONE))
        else $error("result appeared without a finished transaction");

    a_run_starts_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_step == '0) |-> $past(r_state == S_IDLE))
        else $error("ring turn started mid-transaction");

    a_pv_after_run: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_pv |-> $past(r_state == S_RUN))
        else $error("accumulate outside the ring turn");

    a_no_coef_write_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state != S_IDLE) |-> !take_coef && !cell_ctl.shift)
        else $error("ring loaded while busy");

endmodule

[src/mdfs_cell.sv]
module mdfs_cell #(
    parameter logic [mdfs_pkg::COEF_W-1:0] RST_COEF = '0
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  mdfs_pkg::t_cell_ctl           i_ctl,
    input  logic                          i_coef_we_x,
    input  logic                          i_coef_we_y,
    input  logic [mdfs_pkg::COEF_W-1:0]   i_coef_value,
    input  logic [mdfs_pkg::DATA_W-1:0]   i_shift_x,
    input  logic [mdfs_pkg::DATA_W-1:0]   i_shift_y,
    input  logic [mdfs_pkg::DATA_W-1:0]   i_rot_hist_x,
    input  logic [mdfs_pkg::DATA_W-1:0]   i_rot_hist_y,
    input  logic [mdfs_pkg::COEF_W-1:0]   i_rot_coef_x,
    input  logic [mdfs_pkg::COEF_W-1:0]   i_rot_coef_y,
    output logic [mdfs_pkg::DATA_W-1:0]   o_hist_x,
    output logic [mdfs_pkg::DATA_W-1:0]   o_hist_y,
    output logic [mdfs_pkg::COEF_W-1:0]   o_coef_x,
    output logic [mdfs_pkg::COEF_W-1:0]   o_coef_y
);
    import mdfs_pkg::*;

    logic [DATA_W-1:0] r_hist_x;
    logic [DATA_W-1:0] r_hist_y;
    logic [COEF_W-1:0] r_coef_x;
    logic [COEF_W-1:0] r_coef_y;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hist_x <= '0;
            r_hist_y <= '0;
        end else if (i_ctl.clear) begin
            r_hist_x <= '0;
            r_hist_y <= '0;
        end else if (i_ctl.shift) begin
            r_hist_x <= i_shift_x;
            r_hist_y <= i_shift_y;
        end else if (i_ctl.rotate) begin
            r_hist_x <= i_rot_hist_x;
            r_hist_y <= i_rot_hist_y;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_coef_x <= RST_COEF;
            r_coef_y <= RST_COEF;
        end else if (i_ctl.rotate) begin
            r_coef_x <= i_rot_coef_x;
            r_coef_y <= i_rot_coef_y;
        end else begin
            if (i_coef_we_x) begin
                r_coef_x <= i_coef_value;
            end
            if (i_coef_we_y) begin
                r_coef_y <= i_coef_value;
            end
        end
    end

    assign o_hist_x = r_hist_x;
    assign o_hist_y = r_hist_y;
    assign o_coef_x = r_coef_x;
    assign o_coef_y = r_coef_y;

endmodule

[verif/mouse_delta_fir_smoother_checker.sv]
`timescale 1ns / 100ps

module mouse_delta_fir_smoother_checker (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    input  logic                                i_in_ready,
    input  logic                                i_kind,
    input  logic signed [mdfs_pkg::DATA_W-1:0]  i_delta_x,
    input  logic signed [mdfs_pkg::DATA_W-1:0]  i_delta_y,
    input  logic                                i_coef_axis,
    input  logic [mdfs_pkg::SLOT_W-1:0]         i_coef_slot,
    input  logic signed [mdfs_pkg::COEF_W-1:0]  i_coef_value,
    input  logic                                i_out_valid,
    input  logic                                i_out_ready,
    input  logic signed [mdfs_pkg::DATA_W-1:0]  i_out_x,
    input  logic signed [mdfs_pkg::DATA_W-1:0]  i_out_y,
    input  logic                                i_cfg_we,
    input  logic [mdfs_pkg::CFG_IDX_W-1:0]      i_cfg_idx,
    input  logic [mdfs_pkg::CFG_DATA_W-1:0]     i_cfg_data,
    output int                                  o_fail_count,
    output int                                  o_pending,
    output int                                  o_checked
);
    import mdfs_pkg::*;

    localparam int PRINT_CAP = 200;

    typedef struct packed {
        logic signed [DATA_W-1:0] x;
        logic signed [DATA_W-1:0] y;
    } t_motion;

    logic signed [DATA_W-1:0] hist_x [DEF_MAX_TAPS];
    logic signed [DATA_W-1:0] hist_y [DEF_MAX_TAPS];
    logic signed [COEF_W-1:0] coef_x [DEF_MAX_TAPS];
    logic signed [COEF_W-1:0] coef_y [DEF_MAX_TAPS];
    int                       wr_pos;
    int                       active_taps;
    logic                     smoothing_on;
    t_motion                  motion_queue [$];

    task automatic report_mismatch(input string msg);
        if (o_fail_count < PRINT_CAP) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
        o_fail_count++;
    endtask

    function automatic void clear_history();
        int i;
        for (i = 0; i < DEF_MAX_TAPS; i++) begin
            hist_x[i] = '0;
            hist_y[i] = '0;
        end
        wr_pos = 0;
    endfunction

    function automatic void load_defaults();
        int i;
        int unity;
        unity = 1 << DEF_COEF_FRAC_BITS;
        for (i = 0; i < DEF_MAX_TAPS; i++) begin
            coef_x[i] = COEF_W'((i < DEF_TAPS) ? unity / DEF_TAPS : 0);
            coef_y[i] = COEF_W'((i < DEF_TAPS) ? unity / DEF_TAPS : 0);
        end
        // remainder of unity goes to the middle tap
        coef_x[DEF_TAPS / 2] = COEF_W'(int'(coef_x[DEF_TAPS / 2]) + unity % DEF_TAPS);
        coef_y[DEF_TAPS / 2] = COEF_W'(int'(coef_y[DEF_TAPS / 2]) + unity % DEF_TAPS);
        clear_history();
        smoothing_on = 1'b0;
        active_taps  = DEF_TAPS;
    endfunction

    function automatic logic signed [DATA_W-1:0] smooth_axis(
        input logic                     axis,
        input logic signed [DATA_W-1:0] delta
    );
        logic signed [63:0] acc;
        logic signed [63:0] scaled;
        int                 i;
        int                 idx;
        acc = '0;
        if (axis == AXIS_Y) begin
            hist_y[wr_pos] = delta;
        end else begin
            hist_x[wr_pos] = delta;
        end
        // slot i pairs with the sample that is i transactions old
        for (i = 0; i < active_taps; i++) begin
            idx = (wr_pos + active_taps - i) % active_taps;
            if (axis == AXIS_Y) begin
                acc = acc + coef_y[i] * hist_y[idx];
            end else begin
                acc = acc + coef_x[i] * hist_x[idx];
            end
        end
        scaled = acc >>> DEF_COEF_FRAC_BITS;
        if (scaled > 32767) begin
            return 16'sh7fff;
        end
        if (scaled < -32768) begin
            return 16'sh8000;
        end
        return scaled[DATA_W-1:0];
    endfunction

    function automatic void apply_item();
        t_motion m;
        if (i_kind == KIND_COEF) begin
            if (i_coef_axis == AXIS_Y) begin
                coef_y[i_coef_slot] = i_coef_value;
            end else begin
                coef_x[i_coef_slot] = i_coef_value;
            end
            clear_history();
        end else if (!smoothing_on) begin
            m.x = i_delta_x;
            m.y = i_delta_y;
            motion_queue.push_back(m);
        end else begin
            if (wr_pos >= active_taps) begin
                wr_pos = 0;
            end
            m.x = smooth_axis(AXIS_X, i_delta_x);
            m.y = smooth_axis(AXIS_Y, i_delta_y);
            wr_pos = (wr_pos + 1) % active_taps;
            motion_queue.push_back(m);
        end
    endfunction

    function automatic void apply_reg();
        if (i_cfg_idx == REG_FILTER_ENABLE) begin
            smoothing_on = i_cfg_data[0];
        end else if (i_cfg_idx == REG_TAP_COUNT) begin
            if (i_cfg_data >= 1 && i_cfg_data <= DEF_MAX_TAPS) begin
                active_taps = int'(i_cfg_data);
                clear_history();
            end
        end
    endfunction

    always @(posedge i_clk) begin : monitor
        t_motion want;
        if (!i_rst_n) begin
            load_defaults();
            motion_queue.delete();
            o_fail_count = 0;
            o_checked    = 0;
        end else begin
            // results first: a result never belongs to a transaction accepted at the same edge
            if (i_out_valid && i_out_ready) begin
                if (motion_queue.size() == 0) begin
                    report_mismatch($sformatf("unexpected result x=%0d y=%0d",
                                              i_out_x, i_out_y));
                end else begin
                    want = motion_queue.pop_front();
                    o_checked++;
                    if (i_out_x !== want.x || i_out_y !== want.y) begin
                        report_mismatch($sformatf("result %0d: x=%0d (want %0d) y=%0d (want %0d)",
                                                  o_checked, i_out_x, want.x, i_out_y, want.y));
                    end
                end
            end
            if (i_in_valid && i_in_ready) begin
                apply_item();
            end
            if (i_cfg_we) begin
                apply_reg();
            end
        end
        o_pending = motion_queue.size();
    end

endmodule

[verif/mouse_delta_fir_smoother_test.sv]
`timescale 1ns / 100ps

module mouse_delta_fir_smoother_test;
    import mdfs_pkg::*;

    localparam int CYCLE_LIMIT       = 400000;
    localparam int SETTLE_CYCLES     = 48;
    localparam int RANDOM_PHASES     = 10;
    localparam int SAMPLES_PER_PHASE = 52;

    logic                         i_clk;
    logic                         i_rst_n;
    logic                         i_in_valid;
    logic                         o_in_ready;
    logic                         i_kind;
    logic signed [DATA_W-1:0]     i_delta_x;
    logic signed [DATA_W-1:0]     i_delta_y;
    logic                         i_coef_axis;
    logic [SLOT_W-1:0]            i_coef_slot;
    logic signed [COEF_W-1:0]     i_coef_value;
    logic                         o_out_valid;
    logic                         i_out_ready;
    logic signed [DATA_W-1:0]     o_out_x;
    logic signed [DATA_W-1:0]     o_out_y;
    logic                         i_cfg_we;
    logic [CFG_IDX_W-1:0]         i_cfg_idx;
    logic [CFG_DATA_W-1:0]        i_cfg_data;

    int fail_count;
    int pending_count;
    int checked_count;
    int sample_count;
    int coef_count;
    int setting_count;
    bit send_idle_on;
    int send_idle_pct;
    bit stall_on;
    int stall_pct;

    mouse_delta_fir_smoother dut (.*);

    mouse_delta_fir_smoother_checker checker_i (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .i_in_ready   (o_in_ready),
        .i_kind       (i_kind),
        .i_delta_x    (i_delta_x),
        .i_delta_y    (i_delta_y),
        .i_coef_axis  (i_coef_axis),
        .i_coef_slot  (i_coef_slot),
        .i_coef_value (i_coef_value),
        .i_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .i_out_x      (o_out_x),
        .i_out_y      (o_out_y),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_idx    (i_cfg_idx),
        .i_cfg_data   (i_cfg_data),
        .o_fail_count (fail_count),
        .o_pending    (pending_count),
        .o_checked    (checked_count)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("timeout after %0d cycles, %0d results outstanding", CYCLE_LIMIT, pending_count);
        $display("mouse_delta_fir_smoother_test: FAIL");
        $finish;
    end

    // output side back-pressure in random bursts
    initial begin : sink
        int hold;
        hold = 0;
        i_out_ready <= 1'b1;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                hold--;
            end else if (stall_on && $urandom_range(99, 0) < stall_pct) begin
                hold = $urandom_range(14, 0);
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
            end
        end
    end

    function automatic logic signed [DATA_W-1:0] rand_delta();
        logic [31:0] r;
        int          sel;
        sel = $urandom_range(9, 0);
        if (sel < 6) begin
            r = $urandom_range(512, 0) - 256;
        end else if (sel < 8) begin
            r = $urandom_range(8192, 0) - 4096;
        end else begin
            r = $urandom;
        end
        return r[DATA_W-1:0];
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        logic [31:0] r;
        int          sel;
        sel = $urandom_range(9, 0);
        if (sel < 7) begin
            r = $urandom_range(160, 0) - 32;
        end else if (sel < 9) begin
            r = $urandom_range(2048, 0) - 1024;
        end else begin
            r = $urandom;
        end
        return r[COEF_W-1:0];
    endfunction

    task automatic push_item(
        input logic                     kind,
        input logic signed [DATA_W-1:0] dx,
        input logic signed [DATA_W-1:0] dy,
        input logic                     axis,
        input logic [SLOT_W-1:0]        slot,
        input logic signed [COEF_W-1:0] value
    );
        i_in_valid   <= 1'b1;
        i_kind       <= kind;
        i_delta_x    <= dx;
        i_delta_y    <= dy;
        i_coef_axis  <= axis;
        i_coef_slot  <= slot;
        i_coef_value <= value;
        do @(posedge i_clk); while (!o_in_ready);
        if (kind == KIND_COEF) begin
            coef_count++;
        end else begin
            sample_count++;
        end
        if (send_idle_on && $urandom_range(99, 0) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(15, 1)) @(posedge i_clk);
        end
    endtask

    task automatic send_sample(input logic signed [DATA_W-1:0] dx,
                               input logic signed [DATA_W-1:0] dy);
        logic [31:0] r;
        r = $urandom;
        push_item(KIND_SAMPLE, dx, dy, r[31], r[SLOT_W-1:0], r[23:8]);
    endtask

    task automatic send_coef(input logic                     axis,
                             input logic [SLOT_W-1:0]        slot,
                             input logic signed [COEF_W-1:0] value);
        logic [31:0] r;
        r = $urandom;
        push_item(KIND_COEF, r[15:0], r[31:16], axis, slot, value);
    endtask

    // drain all results, then let any coefficient update finish
    task automatic settle();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (pending_count != 0);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0]  idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= data;
        @(posedge i_clk);
        i_cfg_we   <= 1'b0;
        @(posedge i_clk);
    endtask

    initial begin : stimulus
        int                    p;
        int                    n;
        int                    k;
        int                    taps;
        logic [31:0]           r;
        logic [CFG_DATA_W-1:0] reg_val;

        i_rst_n       <= 1'b0;
        i_in_valid    <= 1'b0;
        i_kind        <= KIND_SAMPLE;
        i_delta_x     <= '0;
        i_delta_y     <= '0;
        i_coef_axis   <= AXIS_X;
        i_coef_slot   <= '0;
        i_coef_value  <= '0;
        i_cfg_we      <= 1'b0;
        i_cfg_idx     <= REG_FILTER_ENABLE;
        i_cfg_data    <= '0;
        send_idle_on  = 1'b1;
        send_idle_pct = 25;
        stall_on      = 1'b1;
        stall_pct     = 10;
        sample_count  = 0;
        coef_count    = 0;
        setting_count = 1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // pass-through after reset
        send_sample(16'sh7fff, 16'sh8000);
        send_sample(16'sh8000, 16'sh7fff);
        send_sample(16'sh0000, 16'shffff);
        send_sample(16'sh0001, 16'sh5555);
        settle();

        // default 21-tap smoothing
        write_reg(REG_FILTER_ENABLE, 6'd1);
        setting_count++;
        send_sample(16'sh0400, 16'shfc00);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'sh8000);

        // extreme coefficients drive both saturation limits
        send_coef(AXIS_X, 5'd0, 16'sh7fff);
        send_coef(AXIS_Y, 5'd0, 16'sh8000);
        send_sample(16'sh7fff, 16'sh7fff);
        send_sample(16'sh8000, 16'shffff);
        send_coef(AXIS_X, 5'd31, 16'shffff);
        send_coef(AXIS_Y, 5'd31, 16'sh0001);
        send_sample(16'sh0100, 16'shff00);
        settle();

        // out-of-range tap counts leave the setting and history alone
        write_reg(REG_TAP_COUNT, 6'd0);
        write_reg(REG_TAP_COUNT, 6'd63);
        write_reg(REG_TAP_COUNT, 6'd33);
        send_sample(16'sh1234, 16'shedcb);
        settle();

        write_reg(REG_TAP_COUNT, 6'd32);
        setting_count++;
        send_sample(16'sh7fff, 16'sh0100);
        send_sample(16'sh0002, 16'sh8000);
        settle();

        // single tap, floor rounding of a negative sum
        write_reg(REG_TAP_COUNT, 6'd1);
        setting_count++;
        send_sample(16'shffff, 16'sh0001);
        send_sample(16'sh4000, 16'shc000);
        settle();

        for (p = 0; p < RANDOM_PHASES; p++) begin
            if (p == 0) begin
                taps = DEF_MAX_TAPS;
            end else if (p == 1) begin
                taps = 1;
            end else begin
                taps = $urandom_range(DEF_MAX_TAPS, 1);
            end
            if ($urandom_range(2, 0) == 0) begin
                n = $urandom_range(31, 0);
                reg_val = (n == 0) ? '0 : CFG_DATA_W'(32 + n);
                write_reg(REG_TAP_COUNT, reg_val);
            end
            reg_val = CFG_DATA_W'(taps);
            write_reg(REG_TAP_COUNT, reg_val);
            r = $urandom;
            reg_val = {r[CFG_DATA_W-1:1], (p % 4 != 3)};
            write_reg(REG_FILTER_ENABLE, reg_val);
            setting_count++;

            // last phase runs with no idling on either side
            send_idle_on  = (p < RANDOM_PHASES - 1);
            stall_on      = (p < RANDOM_PHASES - 1);
            send_idle_pct = (p % 3) * 20;
            stall_pct     = ((p + 1) % 3) * 8;

            for (k = 0; k < 4; k++) begin
                r = $urandom;
                send_coef(r[0], SLOT_W'($urandom_range(taps - 1, 0)), rand_coef());
            end
            for (n = 0; n < SAMPLES_PER_PHASE; n++) begin
                if ($urandom_range(49, 0) == 0) begin
                    r = $urandom;
                    send_coef(r[0], r[SLOT_W:1], rand_coef());
                end else begin
                    send_sample(rand_delta(), rand_delta());
                end
                if (p == 4 && n == SAMPLES_PER_PHASE / 2) begin
                    settle();
                end
            end
            settle();
        end

        $display("sent %0d movement samples and %0d coefficient writes over %0d settings",
                 sample_count, coef_count, setting_count);
        $display("compared %0d results: pass-through, 1 to %0d taps, saturation, bad tap counts",
                 checked_count, DEF_MAX_TAPS);
        if (fail_count == 0) begin
            $display("mouse_delta_fir_smoother_test: PASS");
        end else begin
            $display("mouse_delta_fir_smoother_test: FAIL");
        end
        $finish;
    end

endmodule
